// ----- hdl/dual_stepper_ramp_generator_macros.svh -----
// ---------------------------------------------------------------------------
// dual stepper ramp generator assertion macros
// shared concurrent assertion forms, clocked on i_clk, held off in reset
// ---------------------------------------------------------------------------
`ifndef DUAL_STEPPER_RAMP_GENERATOR_MACROS_SVH
`define DUAL_STEPPER_RAMP_GENERATOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DSRG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dsrg assertion failed");

// consequent holds in the cycle after the antecedent
`define DSRG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dsrg assertion failed");

`endif

// ----- hdl/dsrg_pkg.sv -----
// ---------------------------------------------------------------------------
// dsrg_pkg
// shared types, codes, defaults and the step period table
// ---------------------------------------------------------------------------
`default_nettype none

package dsrg_pkg;

    // default sizes
    localparam int DSRG_ROM_DEPTH = 21;
    localparam int DSRG_GOAL_BITS = 24;
    localparam int DSRG_POS_BITS  = 32;

    // fixed field widths
    localparam int PERIOD_W = 13;
    localparam int SPEED_W  = 5;
    localparam int OUT_W    = 112;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // wheel direction codes
    localparam logic [1:0] SIGN_STILL = 2'd0;
    localparam logic [1:0] SIGN_FWD   = 2'd1;
    localparam logic [1:0] SIGN_BACK  = 2'd2;

    // register indexes and reset values
    localparam logic CFG_RAMP_SPAN  = 1'b0;
    localparam logic CFG_SPEED_CEIL = 1'b1;
    localparam logic [7:0] SPAN_RESET = 8'd10;
    localparam logic [4:0] CEIL_RESET = 5'd12;

    // span phase value while no ramp is running
    localparam logic [8:0] PHASE_IDLE = 9'h1FF;

    typedef struct packed {
        logic [7:0] ramp_span;
        logic [4:0] speed_ceiling;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] left_way;
        logic [1:0] right_way;
        logic       use_ramp;
        logic [7:0] level_limit;
    } t_cmd;

    typedef struct packed {
        logic                busy_res;
        logic [PERIOD_W-1:0] period_us;
        logic [SPEED_W-1:0]  speed_level;
        logic                left_pulse;
        logic                right_pulse;
        logic                left_reverse;
        logic                right_reverse;
        logic signed [31:0]  left_position;
        logic signed [31:0]  right_position;
        logic [23:0]         steps_done;
        logic                ramping_now;
    } t_result;

    // step period in microseconds per speed index
    function automatic logic [PERIOD_W-1:0] period_of(input logic [SPEED_W-1:0] idx);
        logic [PERIOD_W-1:0] p;
        unique case (idx)
            5'd0:    p = 13'd6068;
            5'd1:    p = 13'd4821;
            5'd2:    p = 13'd3991;
            5'd3:    p = 13'd3405;
            5'd4:    p = 13'd2969;
            5'd5:    p = 13'd2632;
            5'd6:    p = 13'd2363;
            5'd7:    p = 13'd2145;
            5'd8:    p = 13'd1963;
            5'd9:    p = 13'd1810;
            5'd10:   p = 13'd1679;
            5'd11:   p = 13'd1565;
            5'd12:   p = 13'd1466;
            5'd13:   p = 13'd1379;
            5'd14:   p = 13'd1301;
            5'd15:   p = 13'd1232;
            5'd16:   p = 13'd1170;
            5'd17:   p = 13'd1114;
            5'd18:   p = 13'd1063;
            5'd19:   p = 13'd1016;
            default: p = 13'd973;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dsrg_cfg.sv -----
// ---------------------------------------------------------------------------
// dsrg_cfg
// ramp span and speed ceiling registers behind a plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module dsrg_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [7:0]    i_cfg_data,
    output dsrg_pkg::t_cfg     o_cfg
);
    import dsrg_pkg::*;

    logic [7:0] r_span;
    logic [4:0] r_ceil;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= SPAN_RESET;
            r_ceil <= CEIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAMP_SPAN:  r_span <= i_cfg_data;
                CFG_SPEED_CEIL: r_ceil <= i_cfg_data[4:0];
                default:        r_span <= r_span;
            endcase
        end
    end

    assign o_cfg.ramp_span     = r_span;
    assign o_cfg.speed_ceiling = r_ceil;

endmodule

`default_nettype wire

// ----- hdl/dsrg_engine.sv -----
// ---------------------------------------------------------------------------
// dsrg_engine
// motion state and the single pass update for one operation
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_stepper_ramp_generator_macros.svh"

module dsrg_engine #(
    parameter int ROM_DEPTH = dsrg_pkg::DSRG_ROM_DEPTH,
    parameter int GOAL_BITS = dsrg_pkg::DSRG_GOAL_BITS,
    parameter int POS_BITS  = dsrg_pkg::DSRG_POS_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire dsrg_pkg::t_cmd       i_cmd,
    input  wire logic [GOAL_BITS-1:0] i_goal,
    input  wire dsrg_pkg::t_cfg       i_cfg,
    output dsrg_pkg::t_result         o_res
);
    import dsrg_pkg::*;

    localparam int SW = ((GOAL_BITS > 13) ? GOAL_BITS : 13) + 1;
    localparam logic [GOAL_BITS-1:0] GOAL_MAX = '1;
    localparam logic [5:0] DEPTH6 = 6'(ROM_DEPTH);
    localparam logic [5:0] TOP6   = 6'(ROM_DEPTH - 1);

    function automatic logic [1:0] way_to_sign(input logic [1:0] w);
        logic [1:0] s;
        unique case (w)
            SIGN_FWD:  s = SIGN_FWD;
            SIGN_BACK: s = SIGN_BACK;
            default:   s = SIGN_STILL;
        endcase
        return s;
    endfunction

    // state
    logic                 r_running, n_running;
    logic                 r_ramp, n_ramp;
    logic [1:0]           r_lsign, n_lsign, r_rsign, n_rsign;
    logic [POS_BITS-1:0]  r_lcount, n_lcount, r_rcount, n_rcount;
    logic [GOAL_BITS-1:0] r_goal, n_goal, r_done, n_done;
    logic [SPEED_W-1:0]   r_speed, n_speed;
    logic [8:0]           r_phase, n_phase;
    logic [4:0]           r_cap, n_cap;
    logic                 r_llevel, n_llevel, r_rlevel, n_rlevel;
    logic                 r_ldir, n_ldir, r_rdir, n_rdir;
    logic                 r_lnext, n_lnext, r_rnext, n_rnext;
    logic [PERIOD_W-1:0]  n_period;

    // helper terms
    logic [5:0]           ceil6;
    logic [4:0]           move_cap;
    logic [12:0]          stop_prod, ramp_thresh;
    logic [SW-1:0]        stop_sum;
    logic [GOAL_BITS-1:0] stop_goal, done_inc;
    logic [8:0]           ph1;
    logic                 hit, first_half, can_up, near_end;
    logic [SPEED_W-1:0]   ramp_speed, tick_speed;
    logic [5:0]           rom_idx;

    // move cap from ceiling and limit
    always_comb begin
        ceil6    = ({1'b0, i_cfg.speed_ceiling} > DEPTH6) ? DEPTH6
                                                          : {1'b0, i_cfg.speed_ceiling};
        move_cap = ((i_cmd.level_limit == 8'd0) || (i_cmd.level_limit >= {2'b00, ceil6}))
                   ? ceil6[4:0] : i_cmd.level_limit[4:0];
    end

    // stop goal, saturating
    always_comb begin
        stop_prod = 13'(r_speed) * 13'(i_cfg.ramp_span);
        stop_sum  = SW'(r_done) + SW'(stop_prod);
        stop_goal = (stop_sum > SW'(GOAL_MAX)) ? GOAL_MAX : stop_sum[GOAL_BITS-1:0];
    end

    // ramp speed update for a tick
    always_comb begin
        ph1         = r_phase + 9'd1;
        hit         = ph1 >= {1'b0, i_cfg.ramp_span};
        first_half  = r_done < (r_goal >> 1);
        can_up      = (r_cap != 5'd0) && (({1'b0, r_speed} + 6'd1) < {1'b0, r_cap});
        ramp_thresh = 13'(i_cfg.ramp_span) * 13'(r_cap);
        near_end    = (r_done > r_goal) || (SW'(r_goal - r_done) < SW'(ramp_thresh));
        if (!hit) begin
            ramp_speed = r_speed;
        end else if (first_half) begin
            ramp_speed = can_up ? r_speed + 5'd1 : r_speed;
        end else begin
            ramp_speed = (near_end && (r_speed != 5'd0)) ? r_speed - 5'd1 : r_speed;
        end
        tick_speed = r_ramp ? ramp_speed : 5'd0;
        rom_idx    = ({1'b0, tick_speed} >= DEPTH6) ? TOP6 : {1'b0, tick_speed};
        done_inc   = (r_done != GOAL_MAX) ? r_done + 1'b1 : r_done;
    end

    // next state
    always_comb begin
        n_running = r_running;
        n_ramp    = r_ramp;
        n_lsign   = r_lsign;
        n_rsign   = r_rsign;
        n_lcount  = r_lcount;
        n_rcount  = r_rcount;
        n_goal    = r_goal;
        n_done    = r_done;
        n_speed   = r_speed;
        n_phase   = r_phase;
        n_cap     = r_cap;
        n_llevel  = r_llevel;
        n_rlevel  = r_rlevel;
        n_ldir    = r_ldir;
        n_rdir    = r_rdir;
        n_lnext   = r_lnext;
        n_rnext   = r_rnext;
        n_period  = '0;
        if (i_go) begin
            unique case (i_cmd.op)
                OP_MOVE: begin
                    if (!r_running) begin
                        n_lsign   = way_to_sign(i_cmd.left_way);
                        n_rsign   = way_to_sign(i_cmd.right_way);
                        n_cap     = move_cap;
                        n_goal    = i_goal;
                        n_ramp    = i_cmd.use_ramp;
                        n_phase   = PHASE_IDLE;
                        n_done    = '0;
                        n_speed   = '0;
                        n_running = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (r_ramp) begin
                        n_goal  = stop_goal;
                        n_phase = {1'b0, i_cfg.ramp_span} + 9'd1;
                    end else begin
                        n_speed   = '0;
                        n_running = 1'b0;
                    end
                end
                OP_CLEAR: begin
                    n_lcount = '0;
                    n_rcount = '0;
                end
                default: begin
                    if (r_running) begin
                        n_speed = tick_speed;
                        if (r_ramp) begin
                            n_phase = hit ? 9'd0 : ph1;
                        end
                        n_period = period_of(rom_idx[SPEED_W-1:0]);
                        // left wheel step
                        if (r_lsign != SIGN_STILL) begin
                            n_lcount = (r_lsign == SIGN_FWD) ? r_lcount + 1'b1 : r_lcount - 1'b1;
                            n_ldir   = (r_lsign == SIGN_BACK);
                            n_llevel = r_lnext;
                            n_lnext  = ~r_lnext;
                        end
                        // right wheel step
                        if (r_rsign != SIGN_STILL) begin
                            n_rcount = (r_rsign == SIGN_FWD) ? r_rcount + 1'b1 : r_rcount - 1'b1;
                            n_rdir   = (r_rsign == SIGN_BACK);
                            n_rlevel = r_rnext;
                            n_rnext  = ~r_rnext;
                        end
                        n_done = done_inc;
                        if (done_inc >= r_goal) begin
                            n_running = 1'b0;
                            n_phase   = PHASE_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_ramp    <= 1'b0;
            r_lsign   <= SIGN_STILL;
            r_rsign   <= SIGN_STILL;
            r_lcount  <= '0;
            r_rcount  <= '0;
            r_goal    <= '0;
            r_done    <= '0;
            r_speed   <= '0;
            r_phase   <= PHASE_IDLE;
            r_cap     <= '0;
            r_llevel  <= 1'b0;
            r_rlevel  <= 1'b0;
            r_ldir    <= 1'b0;
            r_rdir    <= 1'b0;
            r_lnext   <= 1'b0;
            r_rnext   <= 1'b0;
        end else begin
            r_running <= n_running;
            r_ramp    <= n_ramp;
            r_lsign   <= n_lsign;
            r_rsign   <= n_rsign;
            r_lcount  <= n_lcount;
            r_rcount  <= n_rcount;
            r_goal    <= n_goal;
            r_done    <= n_done;
            r_speed   <= n_speed;
            r_phase   <= n_phase;
            r_cap     <= n_cap;
            r_llevel  <= n_llevel;
            r_rlevel  <= n_rlevel;
            r_ldir    <= n_ldir;
            r_rdir    <= n_rdir;
            r_lnext   <= n_lnext;
            r_rnext   <= n_rnext;
        end
    end

    // result word from the updated state
    always_comb begin
        o_res.busy_res       = n_running;
        o_res.period_us      = n_period;
        o_res.speed_level    = n_speed;
        o_res.left_pulse     = n_llevel;
        o_res.right_pulse    = n_rlevel;
        o_res.left_reverse   = n_ldir;
        o_res.right_reverse  = n_rdir;
        o_res.left_position  = 32'(signed'(n_lcount));
        o_res.right_position = 32'(signed'(n_rcount));
        o_res.steps_done     = 24'(n_done);
        o_res.ramping_now    = n_running && n_ramp;
    end

    // checks
    `DSRG_ASSERT_NXT(a_idle_tick_keeps_done, i_go && (i_cmd.op == OP_TICK) && !r_running, $stable(r_done))
    `DSRG_ASSERT_NOW(a_speed_below_cap, 1'b1, (r_speed == 5'd0) || (r_speed < r_cap))
    `DSRG_ASSERT_NOW(a_period_only_on_tick, i_go && (i_cmd.op != OP_TICK), o_res.period_us == '0)

endmodule

`default_nettype wire

// ----- hdl/dual_stepper_ramp_generator.sv -----
// an accepted word is held in the input register, and its result is then registered in the result register
// throughput: one item per cycle while the output is not stalled, set by the single registered update pass
// a stalled output holds one result while one more item waits in the input register
// reset: synchronous active-low i_rst_n idles motion, clears counters and step pins,
//   and loads ramp span 10 and speed ceiling 12
// ---------------------------------------------------------------------------
// dual_stepper_ramp_generator
// two-wheel trapezoidal step ramp generator on a stream interface
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_stepper_ramp_generator_macros.svh"

module dual_stepper_ramp_generator #(
    parameter int ROM_DEPTH = dsrg_pkg::DSRG_ROM_DEPTH,
    parameter int GOAL_BITS = dsrg_pkg::DSRG_GOAL_BITS,
    parameter int POS_BITS  = dsrg_pkg::DSRG_POS_BITS,
    localparam int IN_W     = ((15 + GOAL_BITS + 7) / 8) * 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [7:0]                 i_cfg_data,
    // input stream
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // op, left_way, right_way, step_goal, use_ramp, level_limit
    input  wire logic [IN_W-1:0]            s_axis_tdata,
    // output stream
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // busy_res, period_us, speed_level, left_pulse, right_pulse, left_reverse,
    // right_reverse, left_position, right_position, steps_done, ramping_now
    output logic [dsrg_pkg::OUT_W-1:0]      m_axis_tdata
);
    import dsrg_pkg::*;

    t_cfg                 cfg;
    t_cmd                 r_cmd;
    logic [GOAL_BITS-1:0] r_goal;
    logic                 r_in_vld;
    t_result              r_out, res;
    logic                 r_out_vld;
    logic                 go;

    // configuration registers
    dsrg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake: process when the output register is free or being drained
    assign go            = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd.op          <= s_axis_tdata[1:0];
            r_cmd.left_way    <= s_axis_tdata[3:2];
            r_cmd.right_way   <= s_axis_tdata[5:4];
            r_goal            <= s_axis_tdata[6 +: GOAL_BITS];
            r_cmd.use_ramp    <= s_axis_tdata[6 + GOAL_BITS];
            r_cmd.level_limit <= s_axis_tdata[7 + GOAL_BITS +: 8];
        end
    end

    // motion engine
    dsrg_engine #(
        .ROM_DEPTH (ROM_DEPTH),
        .GOAL_BITS (GOAL_BITS),
        .POS_BITS  (POS_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_cmd   (r_cmd),
        .i_goal  (r_goal),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (go) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= res;
        end
    end

    // output packing, first field in the low bits
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.ramping_now, r_out.steps_done, r_out.right_position,
                            r_out.left_position, r_out.right_reverse, r_out.left_reverse,
                            r_out.right_pulse, r_out.left_pulse, r_out.speed_level,
                            r_out.period_us, r_out.busy_res};

    // checks
    `DSRG_ASSERT_NXT(a_go_fills_output, go, m_axis_tvalid)
    `DSRG_ASSERT_NXT(a_stall_keeps_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `DSRG_ASSERT_NOW(a_ramp_implies_busy, r_out_vld && r_out.ramping_now, r_out.busy_res)

endmodule

`default_nettype wire
